// ===== hw/rtl/limit_order_matcher_assert.svh =====
// Assertion macros for the order matcher.
`ifndef LIMIT_ORDER_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_MATCHER_ASSERT_SVH
`define LOM_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (c)) \
        else $error("lom assertion failed");
`define LOM_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (c)) \
        else $error("lom assertion failed");
`endif

// ===== hw/rtl/lom_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lom_pkg;
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_PRICE = 3'd1;
    localparam logic [2:0] ST_BAD_QTY  = 3'd2;
    localparam logic [2:0] ST_NO_IDS   = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [31:0] ID_LIMIT   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        kind;
        logic [31:0] buyer;
        logic [31:0] seller;
        logic [31:0] price;
        logic [31:0] qty;
        logic [31:0] nid;
        logic [31:0] left;
        logic [2:0]  status;
    } result_t;
endpackage
`default_nettype wire

// ===== hw/rtl/limit_order_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Price-time priority limit order book.
// Input channel s_*: one limit order per request (side, limit price, quantity).
// Result channel m_*: zero or more trade reports (item_kind 0) and then one
// summary (item_kind 1, last_of_run 1) carrying the new id, leftover and status.
// The resting book lives in a slot memory with a registered read.
// Each match round sweeps all ORDER_SLOTS entries (one read per cycle) to find
// the best crossing slot, reads it back and fills it. An order with k fills
// runs k rounds, plus one more sweep when a remainder is left, and then its
// summary; a rejected order gets only its summary, with no sweep. The slot
// memory port is what sets the length of a round.
// Only one order is in work at a time; s_ready is high only when idle.
// Results sit in one output register; while the receiver stalls, the sweep runs
// on but the fill and summary steps hold. Reset clears all slot valid bits
// (flip-flops) and sets next id to one; no clearing pass is needed.
module limit_order_matcher #(
    parameter int ORDER_SLOTS = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_buy_not_sell,
    input  wire  [31:0] s_limit_price,
    input  wire  [31:0] s_order_qty,
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_item_kind,
    output logic        m_last_of_run,
    output logic [31:0] m_buyer_id,
    output logic [31:0] m_seller_id,
    output logic [31:0] m_fill_price,
    output logic [31:0] m_fill_qty,
    output logic [31:0] m_new_order_id,
    output logic [31:0] m_left_qty,
    output logic [2:0]  m_status
);
    import lom_pkg::*;
    `include "limit_order_matcher_assert.svh"

    localparam int AW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int CW = $clog2(ORDER_SLOTS + 1);
    localparam logic [CW-1:0] LAST = CW'(ORDER_SLOTS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // memory: {is_buy, price, qty, id}
    logic [96:0] mem [ORDER_SLOTS];
    logic [96:0] rd_reg;
    logic [ORDER_SLOTS-1:0] valid_reg;

    logic [2:0]    state_reg;
    logic [CW-1:0] cnt_reg;      // address issued
    logic          rv_reg;       // rd_reg holds a sweep read
    logic [AW-1:0] raddr_reg;
    logic          buy_reg;
    logic [31:0]   price_reg, qty_reg, id_reg, next_id_reg;
    logic          found_reg;
    logic [AW-1:0] best_reg;
    logic [31:0]   bprice_reg, bid_reg;
    logic          out_valid_reg;
    result_t       out_reg;
    logic          last_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [96:0]   wdata;
    logic [AW-1:0] raddr;
    logic          rd_buy;
    logic [31:0]   rd_price, rd_qty, rd_id;
    logic          cand, better;
    logic [AW-1:0] free_idx;
    logic          free_any;
    logic [31:0]   fill;

    assign rd_buy   = rd_reg[96];
    assign rd_price = rd_reg[95:64];
    assign rd_qty   = rd_reg[63:32];
    assign rd_id    = rd_reg[31:0];

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    always_comb begin
        cand = valid_reg[raddr_reg] && (rd_buy != buy_reg) &&
               (buy_reg ? (rd_price <= price_reg) : (rd_price >= price_reg));
        if (!found_reg) begin
            better = 1'b1;
        end else if (rd_price != bprice_reg) begin
            better = buy_reg ? (rd_price < bprice_reg) : (rd_price > bprice_reg);
        end else begin
            better = rd_id < bid_reg;
        end
    end

    assign fill = (qty_reg < rd_qty) ? qty_reg : rd_qty;
    assign raddr = (state_reg == S_FETCH || state_reg == S_FILL) ? best_reg :
                   cnt_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        rd_reg <= mem[raddr];
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            next_id_reg   <= 32'd1;
            out_valid_reg <= 1'b0;
            rv_reg        <= 1'b0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            rv_reg    <= 1'b0;
            raddr_reg <= raddr;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        buy_reg   <= s_buy_not_sell;
                        price_reg <= s_limit_price;
                        qty_reg   <= s_order_qty;
                        id_reg    <= next_id_reg;
                        if (s_limit_price == '0 || s_order_qty == '0 ||
                            next_id_reg == ID_LIMIT) begin
                            out_valid_reg <= 1'b1;
                            last_reg      <= 1'b1;
                            out_reg       <= '{kind: 1'b1, buyer: '0, seller: '0,
                                price: '0, qty: '0, nid: '0, left: s_order_qty,
                                status: (s_limit_price == '0) ? ST_BAD_PRICE :
                                        (s_order_qty == '0) ? ST_BAD_QTY : ST_NO_IDS};
                        end else begin
                            next_id_reg <= next_id_reg + 32'd1;
                            state_reg   <= S_SCAN;
                            cnt_reg     <= '0;
                            found_reg   <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    if (cnt_reg != CW'(ORDER_SLOTS)) begin
                        cnt_reg <= cnt_reg + 1'b1;
                        rv_reg  <= 1'b1;
                    end
                    if (rv_reg && cand && better) begin
                        found_reg  <= 1'b1;
                        best_reg   <= raddr_reg;
                        bprice_reg <= rd_price;
                        bid_reg    <= rd_id;
                    end
                    if (rv_reg && raddr_reg == LAST[AW-1:0] &&
                        cnt_reg == CW'(ORDER_SLOTS)) begin
                        state_reg <= (found_reg || (cand && better)) ? S_FETCH : S_DONE;
                    end
                end
                S_FETCH: begin
                    state_reg <= S_FILL;
                end
                S_FILL: begin
                    if (!out_valid_reg) begin
                        out_valid_reg <= 1'b1;
                        last_reg      <= 1'b0;
                        out_reg <= '{kind: 1'b0,
                            buyer: buy_reg ? id_reg : rd_id,
                            seller: buy_reg ? rd_id : id_reg,
                            price: rd_price, qty: fill, nid: '0, left: '0,
                            status: ST_OK};
                        qty_reg <= qty_reg - fill;
                        if (rd_qty == fill) begin
                            valid_reg[best_reg] <= 1'b0;
                        end
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                    state_reg <= (qty_reg == '0) ? S_DONE : S_SCAN;
                end
                S_DONE: begin
                    if (!out_valid_reg) begin
                        out_valid_reg <= 1'b1;
                        last_reg      <= 1'b1;
                        out_reg <= '{kind: 1'b1, buyer: '0, seller: '0, price: '0,
                            qty: '0, nid: id_reg, left: qty_reg,
                            status: (qty_reg != '0 && !free_any) ? ST_FULL : ST_OK};
                        if (qty_reg != '0 && free_any) begin
                            valid_reg[free_idx] <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = best_reg;
        wdata = {rd_buy, rd_price, rd_qty - fill, rd_id};
        if (state_reg == S_FILL && !out_valid_reg && rd_qty != fill) begin
            we = 1'b1;
        end else if (state_reg == S_DONE && !out_valid_reg && qty_reg != '0 &&
                     free_any) begin
            we    = 1'b1;
            waddr = free_idx;
            wdata = {buy_reg, price_reg, qty_reg, id_reg};
        end
    end

    assign m_item_kind    = out_reg.kind;
    assign m_last_of_run  = last_reg;
    assign m_buyer_id     = out_reg.buyer;
    assign m_seller_id    = out_reg.seller;
    assign m_fill_price   = out_reg.price;
    assign m_fill_qty     = out_reg.qty;
    assign m_new_order_id = out_reg.nid;
    assign m_left_qty     = out_reg.left;
    assign m_status       = out_reg.status;

    `LOM_ASSERT_IMP(a_idle_ready, s_ready, state_reg == S_IDLE)
    `LOM_ASSERT_IMP(a_trade_zero_status, m_valid && !m_item_kind, m_status == ST_OK)
    `LOM_ASSERT_NXT(a_accept_busy, s_valid && s_ready, !s_ready)
endmodule
`default_nettype wire
